>>> sv/countdown_timer_bank_macros.svh
// ----------------------------------------------------------------------------
// countdown_timer_bank_macros: assertion macros for the timer bank
// Assertions compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef COUNTDOWN_TIMER_BANK_MACROS_SVH
`define COUNTDOWN_TIMER_BANK_MACROS_SVH

`ifndef SYNTH
// Checked only while out of reset.
`define CTB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define CTB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CTB_ASSERT(lbl, prop, msg)
`define CTB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> sv/ctb_pkg.sv
// ----------------------------------------------------------------------------
// ctb_pkg: shared types and constants of the countdown timer bank
// Field widths, result kinds, command classes and the slot record layout.
// ----------------------------------------------------------------------------
`default_nettype none

package ctb_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int DUR_W     = 32;
	localparam int TAG_W     = 16;
	localparam int CNT_W     = 16;
	localparam int SLOT_W    = 4;
	localparam int KIND_W    = 2;

	localparam logic [CNT_W-1:0] SLICE_RST = 16'd10;
	localparam logic             OP_TICK   = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_ACCEPT = 2'd0,
		KIND_REFUSE = 2'd1,
		KIND_FIRED  = 2'd2,
		KIND_SCHED  = 2'd3
	} kind_t;

	// class of a queued command, decided by the front
	typedef enum logic [1:0] {
		CLS_START  = 2'd0,
		CLS_REFUSE = 2'd1,
		CLS_TICK   = 2'd2
	} cls_t;

	typedef struct packed {
		cls_t             cls;
		logic [DUR_W-1:0] duration;
		logic             periodic;
		logic [TAG_W-1:0] tag;
	} cmd_t;

	typedef struct packed {
		logic [DUR_W-1:0] remaining;
		logic [DUR_W-1:0] reload;
		logic             periodic;
		logic [TAG_W-1:0] tag;
	} slot_rec_t;

	localparam int SLOT_REC_W = $bits(slot_rec_t);

	typedef struct packed {
		kind_t             kind;
		logic [SLOT_W-1:0] slot;
		logic [TAG_W-1:0]  tag;
	} res_t;

endpackage

`default_nettype wire

>>> sv/ctb_if.sv
// ----------------------------------------------------------------------------
// ctb_if: item and result channels of the countdown timer bank
// Valid/ready channels; a transfer happens when both are high at an edge.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctb_item_if;
	logic                       valid;
	logic                       ready;
	logic                       op;
	logic [ctb_pkg::DUR_W-1:0]  duration;
	logic                       periodic;
	logic [ctb_pkg::TAG_W-1:0]  tag;

	modport source (output valid, op, duration, periodic, tag, input ready);
	modport sink   (input valid, op, duration, periodic, tag, output ready);
endinterface

interface ctb_result_if;
	logic                       valid;
	logic                       ready;
	logic [ctb_pkg::KIND_W-1:0] kind;
	logic [ctb_pkg::SLOT_W-1:0] slot;
	logic [ctb_pkg::TAG_W-1:0]  fired_tag;
	logic                       last;

	modport source (output valid, kind, slot, fired_tag, last, input ready);
	modport sink   (input valid, kind, slot, fired_tag, last, output ready);
endinterface

`default_nettype wire

>>> sv/countdown_timer_bank.sv
// ----------------------------------------------------------------------------
// countdown_timer_bank: bank of countdown timer slots with a slice counter
// item channel: op 0 starts a timer in the lowest free slot (duration,
// periodic, tag); op 1 is one tick. result channel: kind, slot, fired_tag,
// last; last marks the final result of an item. cfg_we/cfg_wdata write
// slice_ticks; write it only while the bank is idle.
// Items enter a two-entry queue in the cycle they arrive. A start writes its
// one result in the held register in ST_START; ST_FIN moves it to the output.
// A tick walks the slot RAM, with one read and one write port, one slot per
// cycle while each fired result can be held, then updates the slice counter.
// Fired results come in slot order, a schedule event after them.
// Items are executed one at a time; the queue accepts up to two more meanwhile.
// Reset clears all slots to free, the slice count to zero and slice_ticks
// to 10; the slot RAM needs no clearing since data of free slots is never used.
// A stalled receiver stops the walk at a firing slot once the output register
// and one held result are full; nothing is dropped and intake continues until
// the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

`include "countdown_timer_bank_macros.svh"

module countdown_timer_bank #(
	parameter int TIMER_SLOTS = ctb_pkg::SLOTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	ctb_item_if.sink                  item,
	ctb_result_if.source              result,
	input  logic                      cfg_we,
	input  logic [ctb_pkg::CNT_W-1:0] cfg_wdata
);

	ctb_pkg::cmd_t             cmd;
	logic                      cmd_valid;
	logic                      cmd_ready;
	logic [ctb_pkg::CNT_W-1:0] slice_ticks_q;

	// slice length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_ticks_q <= ctb_pkg::SLICE_RST;
		end else if (cfg_we) begin
			slice_ticks_q <= cfg_wdata;
		end
	end

	// front: take and classify items, queue them
	ctb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready)
	);

	// back: grant slots, walk the timers, emit results
	ctb_back #(
		.TIMER_SLOTS (TIMER_SLOTS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.slice_ticks (slice_ticks_q),
		.result      (result)
	);

	// a start answer is always the only result of its item
	`CTB_ASSERT(a_start_alone, result.valid && (result.kind == ctb_pkg::KIND_ACCEPT || result.kind == ctb_pkg::KIND_REFUSE) |-> result.last, "start result without last")

	// the schedule event always closes a tick
	`CTB_ASSERT(a_sched_last, result.valid && result.kind == ctb_pkg::KIND_SCHED |-> result.last, "schedule event not last")

	// only fired results carry a tag
	`CTB_ASSERT(a_tag_zero, result.valid && result.kind != ctb_pkg::KIND_FIRED |-> result.fired_tag == '0, "tag on a non-fired result")

	// no result once an edge has seen reset
	`CTB_ASSERT_ALWAYS(a_rst_quiet, !arst_n |=> !result.valid, "result valid in reset")

endmodule

`default_nettype wire

>>> sv/ctb_ram.sv
// ----------------------------------------------------------------------------
// ctb_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ctb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> sv/ctb_front.sv
// ----------------------------------------------------------------------------
// ctb_front: item intake of the countdown timer bank
// Classify each item and hold it in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ctb_front (
	input  logic          clk,
	input  logic          arst_n,
	ctb_item_if.sink      item,
	output ctb_pkg::cmd_t cmd,
	output logic          cmd_valid,
	input  logic          cmd_ready
);

	localparam int Depth = 2;

	ctb_pkg::cmd_t q_q [Depth];
	ctb_pkg::cmd_t cls_cmd;
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          push;
	logic          pop;

	// classify: tick, start with a usable duration, or a start to refuse
	always_comb begin
		cls_cmd.duration = item.duration;
		cls_cmd.periodic = item.periodic;
		cls_cmd.tag      = item.tag;
		if (item.op == ctb_pkg::OP_TICK) begin
			cls_cmd.cls = ctb_pkg::CLS_TICK;
		end else if (item.duration == '0) begin
			cls_cmd.cls = ctb_pkg::CLS_REFUSE;
		end else begin
			cls_cmd.cls = ctb_pkg::CLS_START;
		end
	end

	assign item.ready = (cnt_q != 2'(Depth));
	assign push       = item.valid && item.ready;
	assign cmd_valid  = (cnt_q != 2'd0);
	assign pop        = cmd_valid && cmd_ready;
	assign cmd        = q_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				q_q[wr_ptr_q] <= cls_cmd;
				wr_ptr_q      <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

`default_nettype wire

>>> sv/ctb_back.sv
// ----------------------------------------------------------------------------
// ctb_back: execution side of the countdown timer bank
// Grant slots, walk the slot RAM on ticks, run the slice counter, emit results.
// ----------------------------------------------------------------------------
`default_nettype none

module ctb_back #(
	parameter int TIMER_SLOTS = ctb_pkg::SLOTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ctb_pkg::cmd_t             cmd,
	input  logic                      cmd_valid,
	output logic                      cmd_ready,
	input  logic [ctb_pkg::CNT_W-1:0] slice_ticks,
	ctb_result_if.source              result
);

	localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CW = $clog2(TIMER_SLOTS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_WALK,
		ST_SLICE,
		ST_FIN
	} state_t;

	state_t                    state_q;
	ctb_pkg::cmd_t             cmd_q;
	logic [TIMER_SLOTS-1:0]    active_q;
	logic [CW-1:0]             rd_cnt_q;
	logic                      v_s1;
	logic [IW-1:0]             idx_s1;
	logic [ctb_pkg::CNT_W-1:0] slice_cnt_q;
	logic                      pend_v_q;
	ctb_pkg::res_t             pend_q;
	logic                      out_v_q;
	ctb_pkg::res_t             out_q;
	logic                      out_last_q;

	logic                           ram_we;
	logic [IW-1:0]                  ram_wa;
	ctb_pkg::slot_rec_t             ram_wd;
	logic                           ram_re;
	logic [ctb_pkg::SLOT_REC_W-1:0] ram_rdata;
	ctb_pkg::slot_rec_t             rec;
	logic [ctb_pkg::DUR_W-1:0]      dec;

	logic                      free_found;
	logic [IW-1:0]             free_idx;
	logic                      out_free;
	logic                      emit_ok;
	logic                      slot_live;
	logic                      fire_s1;
	logic                      adv_s1;
	logic                      s1_free;
	logic                      walk_done;
	logic [ctb_pkg::CNT_W-1:0] cnt_inc;
	logic                      sched_due;
	logic                      new_v;
	ctb_pkg::res_t             new_res;
	logic                      fin_flush;
	logic                      load_out;

	ctb_ram #(
		.WIDTH (ctb_pkg::SLOT_REC_W),
		.DEPTH (TIMER_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_wa),
		.wdata (ram_wd),
		.re    (ram_re),
		.raddr (rd_cnt_q[IW-1:0]),
		.rdata (ram_rdata)
	);

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	assign rec       = ctb_pkg::slot_rec_t'(ram_rdata);
	assign dec       = rec.remaining - ctb_pkg::DUR_W'(1);
	assign out_free  = !out_v_q || result.ready;
	assign emit_ok   = !pend_v_q || out_free;
	assign slot_live = v_s1 && active_q[idx_s1];
	assign fire_s1   = slot_live && (dec == '0);
	assign adv_s1    = !fire_s1 || emit_ok;
	assign s1_free   = !v_s1 || adv_s1;
	assign walk_done = (rd_cnt_q == CW'(TIMER_SLOTS));
	assign cnt_inc   = slice_cnt_q + ctb_pkg::CNT_W'(1);
	assign sched_due = (cnt_inc >= slice_ticks);
	assign cmd_ready = (state_q == ST_IDLE);

	always_comb begin
		ram_we       = 1'b0;
		ram_wa       = free_idx;
		ram_wd       = rec;
		ram_re       = 1'b0;
		new_v        = 1'b0;
		new_res.kind = ctb_pkg::KIND_REFUSE;
		new_res.slot = '0;
		new_res.tag  = '0;
		fin_flush    = 1'b0;
		case (state_q)
			ST_START: begin
				new_v            = 1'b1;
				ram_wd.remaining = cmd_q.duration;
				ram_wd.reload    = cmd_q.duration;
				ram_wd.periodic  = cmd_q.periodic;
				ram_wd.tag       = cmd_q.tag;
				if (cmd_q.cls == ctb_pkg::CLS_START && free_found) begin
					ram_we       = 1'b1;
					new_res.kind = ctb_pkg::KIND_ACCEPT;
					new_res.slot = ctb_pkg::SLOT_W'(free_idx);
				end
			end
			ST_WALK: begin
				ram_re = !walk_done && s1_free;
				ram_wa = idx_s1;
				if (fire_s1) begin
					ram_wd.remaining = rec.periodic ? rec.reload : '0;
				end else begin
					ram_wd.remaining = dec;
				end
				ram_we = slot_live && adv_s1;
				if (fire_s1 && adv_s1) begin
					new_v        = 1'b1;
					new_res.kind = ctb_pkg::KIND_FIRED;
					new_res.slot = ctb_pkg::SLOT_W'(idx_s1);
					new_res.tag  = rec.tag;
				end
			end
			ST_SLICE: begin
				if (sched_due && emit_ok) begin
					new_v        = 1'b1;
					new_res.kind = ctb_pkg::KIND_SCHED;
				end
			end
			ST_FIN: begin
				fin_flush = pend_v_q && out_free;
			end
			default: begin
			end
		endcase
	end

	// a held result moves out when a newer one arrives or the item ends
	assign load_out = (new_v && pend_v_q) || fin_flush;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= '0;
			rd_cnt_q    <= '0;
			v_s1        <= 1'b0;
			slice_cnt_q <= '0;
			pend_v_q    <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					rd_cnt_q <= '0;
					v_s1     <= 1'b0;
					if (cmd_valid) begin
						cmd_q   <= cmd;
						state_q <= (cmd.cls == ctb_pkg::CLS_TICK) ? ST_WALK : ST_START;
					end
				end
				ST_START: begin
					if (ram_we) begin
						active_q[free_idx] <= 1'b1;
					end
					state_q <= ST_FIN;
				end
				ST_WALK: begin
					if (s1_free) begin
						v_s1   <= ram_re;
						idx_s1 <= rd_cnt_q[IW-1:0];
					end
					if (ram_re) begin
						rd_cnt_q <= rd_cnt_q + CW'(1);
					end
					if (fire_s1 && adv_s1 && !rec.periodic) begin
						active_q[idx_s1] <= 1'b0;
					end
					if (walk_done && s1_free) begin
						state_q <= ST_SLICE;
					end
				end
				ST_SLICE: begin
					if (!sched_due) begin
						slice_cnt_q <= cnt_inc;
						state_q     <= ST_FIN;
					end else if (emit_ok) begin
						slice_cnt_q <= '0;
						state_q     <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!pend_v_q || out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (new_v) begin
				pend_q   <= new_res;
				pend_v_q <= 1'b1;
			end else if (fin_flush) begin
				pend_v_q <= 1'b0;
			end

			if (load_out) begin
				out_v_q    <= 1'b1;
				out_q      <= pend_q;
				out_last_q <= fin_flush;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign result.valid     = out_v_q;
	assign result.kind      = out_q.kind;
	assign result.slot      = out_q.slot;
	assign result.fired_tag = out_q.tag;
	assign result.last      = out_last_q;

endmodule

`default_nettype wire
